// ===== rtl/core/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types and constants of the shift register switch scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

  localparam int NUM_SWITCHES_DEF = 22;

  localparam int IDX_W  = 6;  // bit_index width
  localparam int CTRL_W = 7;  // control number / value width
  localparam int CHAN_W = 5;  // channel width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_BASE      = 2'd1;

  localparam logic [CHAN_W-1:0] MIDI_CHANNEL_RST = 5'd2;
  localparam logic [CTRL_W-1:0] CC_BASE_RST      = 7'd1;

  localparam logic [CTRL_W-1:0] VALUE_ON  = 7'd127;
  localparam logic [CTRL_W-1:0] VALUE_OFF = 7'd0;

  // Line levels and read strobe from the sequencer for the current step.
  typedef struct packed {
    logic             clock;
    logic             shift_load;
    logic             read_en;
    logic [IDX_W-1:0] index;
  } seq_ctrl_t;

  // One control event (all zero when no switch changed).
  typedef struct packed {
    logic              valid;
    logic [CTRL_W-1:0] number;
    logic [CTRL_W-1:0] value;
    logic [CHAN_W-1:0] channel;
  } ctrl_event_t;

endpackage

`default_nettype wire

// ===== rtl/core/shift_register_switch_scanner.sv =====
// ----------------------------------------------------------------------------
// shift_register_switch_scanner
// Scans switches through an external parallel-in serial-out shift register
// and reports level changes as control events.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | data_in (serial line level per tick)
//  out     | out_valid / out_stall | clock_out, shift_load_out, event_valid,
//          |                       | control_number, control_value,
//          |                       | event_channel
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle sustained while out_stall stays low; an item passes
//  through the input register, then the result register.
//  Reset (rst, synchronous) puts the scan at the load phase, index zero,
//  all last levels low, channel 2 and control base 1.
//  out_stall holds the result register; the input register keeps taking
//  items until it is full, so in_stall rises only with both stages loaded.
//  cfg_ready is always high; a write to an unknown index is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_register_switch_scanner import ssw_pkg::*; #(
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  data_in,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       clock_out,
  output logic                       shift_load_out,
  output logic                       event_valid,
  output logic [CTRL_W-1:0]          control_number,
  output logic [CTRL_W-1:0]          control_value,
  output logic [CHAN_W-1:0]          event_channel,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CHAN_W-1:0] midi_channel;
  logic [CTRL_W-1:0] cc_base;

  logic        s1_valid;
  logic        s1_data;
  logic        advance;
  seq_ctrl_t   ctrl;
  ctrl_event_t ev;

  // Configuration registers: always ready; write only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= MIDI_CHANNEL_RST;
      cc_base      <= CC_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIDI_CHANNEL: midi_channel <= cfg_data[CHAN_W-1:0];
        CFG_CC_BASE:      cc_base      <= cfg_data[CTRL_W-1:0];
        default:          ;
      endcase
    end
  end

  // Move the held item into the result register when that register is
  // empty or its item is being taken this cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register: hold one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= data_in;
    end
  end

  // Scan state advances exactly once per item, as it enters the result
  // register.
  ssw_seq #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step_en(advance),
    .ctrl   (ctrl)
  );

  ssw_levels #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_levels (
    .clk         (clk),
    .rst         (rst),
    .step_en     (advance),
    .ctrl        (ctrl),
    .level       (s1_data),
    .cc_base     (cc_base),
    .midi_channel(midi_channel),
    .event_out   (ev)
  );

  // Result register: load on advance, drop when taken, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      clock_out      <= ctrl.clock;
      shift_load_out <= ctrl.shift_load;
      event_valid    <= ev.valid;
      control_number <= ev.number;
      control_value  <= ev.value;
      event_channel  <= ev.channel;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_event_in_shift_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid |-> shift_load_out)
    else $error("event reported outside a read");

  a_event_value_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid |-> control_value == VALUE_ON || control_value == VALUE_OFF)
    else $error("bad control value");

  a_quiet_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> control_number == '0 && event_channel == '0)
    else $error("fields set without an event");

endmodule

`default_nettype wire

// ===== rtl/core/ssw_seq.sv =====
// ----------------------------------------------------------------------------
// ssw_seq
// Scan sequencer: load, read, clock-low, clock-high, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_seq import ssw_pkg::*; #(
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step_en,
  output seq_ctrl_t      ctrl
);

  typedef enum logic [2:0] {
    PH_LOAD     = 3'd0,
    PH_READ     = 3'd1,
    PH_CLK_LOW  = 3'd2,
    PH_CLK_HIGH = 3'd3,
    PH_CLEAR    = 3'd4
  } phase_t;

  localparam logic [IDX_W:0] LAST_CNT = (IDX_W + 1)'(NUM_SWITCHES);

  phase_t           scan_phase;
  phase_t           scan_phase_next;
  logic [IDX_W-1:0] bit_index;
  logic [IDX_W-1:0] bit_index_next;
  logic             last_read;

  assign last_read = ({1'b0, bit_index} + (IDX_W + 1)'(1)) >= LAST_CNT;

  always_comb begin
    ctrl.clock      = 1'b0;
    ctrl.shift_load = 1'b1;
    ctrl.read_en    = 1'b0;
    ctrl.index      = bit_index;
    scan_phase_next = PH_LOAD;
    bit_index_next  = bit_index;
    case (scan_phase)
      PH_LOAD: begin
        scan_phase_next = PH_READ;
      end
      PH_READ: begin
        // clock stays high from the previous pulse except on the first bit
        ctrl.clock      = (bit_index != '0);
        ctrl.read_en    = 1'b1;
        scan_phase_next = last_read ? PH_CLEAR : PH_CLK_LOW;
      end
      PH_CLK_LOW: begin
        scan_phase_next = PH_CLK_HIGH;
      end
      PH_CLK_HIGH: begin
        ctrl.clock      = 1'b1;
        bit_index_next  = bit_index + IDX_W'(1);
        scan_phase_next = PH_READ;
      end
      default: begin
        ctrl.shift_load = 1'b0;
        bit_index_next  = '0;
        scan_phase_next = PH_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase <= PH_LOAD;
      bit_index  <= '0;
    end else if (step_en) begin
      scan_phase <= scan_phase_next;
      bit_index  <= bit_index_next;
    end
  end

  a_clear_zeroes_index: assert property (@(posedge clk) disable iff (rst)
    step_en && !ctrl.shift_load |=> bit_index == '0)
    else $error("index not cleared after clear phase");

  a_read_in_shift_mode: assert property (@(posedge clk) disable iff (rst)
    ctrl.read_en |-> ctrl.shift_load)
    else $error("read while in parallel load");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, bit_index} < LAST_CNT))
    else $error("bit index beyond last switch");

endmodule

`default_nettype wire

// ===== rtl/core/ssw_levels.sv =====
// ----------------------------------------------------------------------------
// ssw_levels
// Last switch levels, change compare and control event build.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_levels import ssw_pkg::*; #(
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_en,
  input  wire seq_ctrl_t         ctrl,
  input  wire logic              level,
  input  wire logic [CTRL_W-1:0] cc_base,
  input  wire logic [CHAN_W-1:0] midi_channel,
  output ctrl_event_t            event_out
);

  localparam int LW = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam logic [IDX_W:0] NUM_CNT = (IDX_W + 1)'(NUM_SWITCHES);

  logic [NUM_SWITCHES-1:0] last_levels;
  logic                    in_range;
  logic [LW-1:0]           sel;
  logic                    changed;

  assign in_range = {1'b0, ctrl.index} < NUM_CNT;
  assign sel      = ctrl.index[LW-1:0];
  assign changed  = ctrl.read_en && in_range && (last_levels[sel] != level);

  always_comb begin
    event_out.valid   = changed;
    event_out.number  = '0;
    event_out.value   = '0;
    event_out.channel = '0;
    if (changed) begin
      event_out.number  = cc_base + CTRL_W'(ctrl.index);
      event_out.value   = level ? VALUE_OFF : VALUE_ON;
      event_out.channel = midi_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels <= '0;
    end else if (step_en && changed) begin
      last_levels[sel] <= level;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_shift_register_switch_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shift_register_switch_scanner
// Self-checking bench for the switch scanner: drives scan ticks with directed
// and random serial line levels, predicts line levels and control events tick
// by tick, and compares every result with the prediction across several
// register settings and handshake pressure modes.
// ----------------------------------------------------------------------------
module tb_shift_register_switch_scanner;
  import ssw_pkg::*;

  localparam int NUM_SW         = NUM_SWITCHES_DEF;
  localparam int ITEMS_PER_PASS = 250;
  localparam int NUM_PASSES     = 8;
  localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int MAX_PRINTS     = 40;

  // Spare register indexes: writes there must leave the scanner untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    STEP_LOAD, STEP_READ, STEP_CLK_LOW, STEP_CLK_HIGH, STEP_CLEAR
  } scan_step_e;

  // Line levels and event of one tick, in port order.
  typedef struct packed {
    logic        clock;
    logic        shift_load;
    ctrl_event_t ev;
  } scan_result_t;

  typedef struct packed {
    logic         level;
    logic         typed;  // want holds a hand-written result
    scan_result_t want;
  } directed_row_t;

  localparam ctrl_event_t  NO_EVENT   = '0;
  localparam scan_result_t QUIET_CLK0 = '{1'b0, 1'b1, NO_EVENT};
  localparam scan_result_t QUIET_CLK1 = '{1'b1, 1'b1, NO_EVENT};

  // Register settings of the first passes: extremes, out-of-range channel,
  // and a base that makes the control number wrap. Later passes randomize.
  localparam logic [CFG_DATA_W-1:0] CHAN_SETTINGS [4] = '{7'd1, 7'd16, 7'h7F, 7'h60};
  localparam logic [CFG_DATA_W-1:0] BASE_SETTINGS [4] = '{7'd0, 7'd106, 7'd127, 7'd120};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  data_in;
  logic                  out_valid;
  logic                  out_stall;
  logic                  clock_out;
  logic                  shift_load_out;
  logic                  event_valid;
  logic [CTRL_W-1:0]     control_number;
  logic [CTRL_W-1:0]     control_value;
  logic [CHAN_W-1:0]     event_channel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: our own copy of the scan sequencer and registers.
  scan_step_e         scan_step;
  logic [IDX_W-1:0]   switch_index;
  logic [NUM_SW-1:0]  switch_level;
  logic [CHAN_W-1:0]  midi_channel_reg;
  logic [CTRL_W-1:0]  cc_base_reg;

  scan_result_t  expected_ticks [$];
  directed_row_t directed_rows [24];

  int error_count;
  int results_seen;
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  shift_register_switch_scanner u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_in        (data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .clock_out      (clock_out),
    .shift_load_out (shift_load_out),
    .event_valid    (event_valid),
    .control_number (control_number),
    .control_value  (control_value),
    .event_channel  (event_channel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted sequencer by one tick and return the lines and
  // event it drives. A read compares the line level with the stored level
  // of the current switch; the control number wraps in 7 bits.
  function automatic scan_result_t predict_tick(input logic level);
    scan_result_t r;
    r = '0;
    r.shift_load = 1'b1;
    case (scan_step)
      STEP_LOAD: begin
        scan_step = STEP_READ;
      end
      STEP_READ: begin
        r.clock = (switch_index != '0);
        if (switch_index < NUM_SW && switch_level[switch_index] != level) begin
          r.ev.valid   = 1'b1;
          r.ev.number  = cc_base_reg + {1'b0, switch_index};
          r.ev.value   = level ? VALUE_OFF : VALUE_ON;
          r.ev.channel = midi_channel_reg;
          switch_level[switch_index] = level;
        end
        scan_step = (int'(switch_index) + 1 >= NUM_SW) ? STEP_CLEAR : STEP_CLK_LOW;
      end
      STEP_CLK_LOW: begin
        scan_step = STEP_CLK_HIGH;
      end
      STEP_CLK_HIGH: begin
        r.clock      = 1'b1;
        switch_index = switch_index + 1'b1;
        scan_step    = STEP_READ;
      end
      default: begin
        r.shift_load = 1'b0;
        switch_index = '0;
        scan_step    = STEP_LOAD;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] result %0d %s: got %0d, expected %0d",
               $time, results_seen, what, got, want);
    error_count++;
  endtask

  task automatic check_tick(input scan_result_t got, input scan_result_t want);
    if (got.clock !== want.clock)
      report_mismatch("clock_out", int'(got.clock), int'(want.clock));
    if (got.shift_load !== want.shift_load)
      report_mismatch("shift_load_out", int'(got.shift_load), int'(want.shift_load));
    if (got.ev.valid !== want.ev.valid)
      report_mismatch("event_valid", int'(got.ev.valid), int'(want.ev.valid));
    if (got.ev.number !== want.ev.number)
      report_mismatch("control_number", int'(got.ev.number), int'(want.ev.number));
    if (got.ev.value !== want.ev.value)
      report_mismatch("control_value", int'(got.ev.value), int'(want.ev.value));
    if (got.ev.channel !== want.ev.channel)
      report_mismatch("event_channel", int'(got.ev.channel), int'(want.ev.channel));
  endtask

  // Present one scan tick, after a random gap when the sender idles. Called
  // and returning just after a falling edge; at most one drive per step.
  task automatic send_tick(input logic level, input logic typed, input scan_result_t want);
    scan_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_in  <= level;
    do @(posedge clk); while (in_stall);
    // Keep the predictor in step even where the row carries its own result.
    predicted = predict_tick(level);
    expected_ticks.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Write one register; cfg_valid stays high for a following write and is
  // dropped by the caller after the last one.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIDI_CHANNEL: midi_channel_reg = value[CHAN_W-1:0];
      CFG_CC_BASE:      cc_base_reg      = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop the input valid and hold until every predicted tick has come back.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_ticks.size() != 0);
  endtask

  // Receiver side: stall at random with the current pressure setting.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unpredicted result count", 1, 0);
      end else begin
        check_tick({clock_out, shift_load_out, event_valid, control_number,
                    control_value, event_channel}, expected_ticks.pop_front());
      end
      results_seen++;
    end
  end

  // End the run if no handshake of any channel happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               STALL_LIMIT, expected_ticks.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] chan_value;
    logic [CFG_DATA_W-1:0] base_value;

    rst                = 1'b1;
    in_valid           = 1'b0;
    data_in            = 1'b0;
    out_stall          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_MIDI_CHANNEL;
    cfg_data           = '0;
    error_count        = 0;
    results_seen       = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    scan_step        = STEP_LOAD;
    switch_index     = '0;
    switch_level     = '0;
    midi_channel_reg = MIDI_CHANNEL_RST;
    cc_base_reg      = CC_BASE_RST;

    // Directed scan start under reset settings (channel 2, base 1). Switch
    // zero goes high, switch one stays low, switch two goes high; the ticks
    // between reads must ignore the line level.
    directed_rows = '{
      '{1'b0, 1'b1, QUIET_CLK0},                                         // load
      '{1'b1, 1'b1, '{1'b0, 1'b1, '{1'b1, 7'd1, VALUE_OFF, MIDI_CHANNEL_RST}}},
      '{1'b1, 1'b1, QUIET_CLK0},                                         // clock low
      '{1'b0, 1'b1, QUIET_CLK1},                                         // clock high
      '{1'b0, 1'b1, QUIET_CLK1},                                         // switch one
      '{1'b1, 1'b0, '0},
      '{1'b1, 1'b0, '0},
      '{1'b1, 1'b1, '{1'b1, 1'b1, '{1'b1, 7'd3, VALUE_OFF, MIDI_CHANNEL_RST}}},
      '{1'b0, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0},           // switch three
      '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},           // switch four
      '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b1, 1'b0, '0},           // switch five
      '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0},           // switch six
      '{1'b0, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0},           // switch seven
      '{1'b1, 1'b0, '0}
    };

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_tick(directed_rows[i].level, directed_rows[i].typed, directed_rows[i].want);

    // Random passes: settle, rewrite registers, then stream random line levels
    // under one pressure mode per pass (none, sender, receiver, both).
    for (int pass = 0; pass < NUM_PASSES; pass++) begin
      drain_results();
      receiver_stall_pct = 0;
      sender_idle_pct    = 0;
      // Let the two pipeline stages empty before touching the registers.
      repeat (2) @(negedge clk);

      if (pass < 4) begin
        chan_value = CHAN_SETTINGS[pass];
        base_value = BASE_SETTINGS[pass];
      end else begin
        chan_value = 7'($urandom_range(0, 127));
        base_value = 7'($urandom_range(0, 127));
      end
      write_register(CFG_SPARE_A, 7'($urandom_range(0, 127)));
      write_register(CFG_MIDI_CHANNEL, chan_value);
      write_register(CFG_CC_BASE, base_value);
      write_register(CFG_SPARE_B, 7'($urandom_range(0, 127)));
      cfg_valid <= 1'b0;

      case (pass % 4)
        1:       begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
        3:       begin sender_idle_pct = 14; receiver_stall_pct = 14; end
        default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase

      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        // Halfway through one pass, hold the sender until the pipe drains.
        if (pass == 3 && n == ITEMS_PER_PASS / 2)
          drain_results();
        send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (expected_ticks.size() != 0)
      report_mismatch("missing result count", expected_ticks.size(), 0);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
